// ----- rtl/core/rmq_pkg.sv -----
// Shared constants for the rotation matrix to quaternion block.
`default_nettype none
package rmq_pkg;

    // Default field format, signed Q2.14
    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    // Words held between the classify stage and the arithmetic pipeline
    localparam int QUEUE_DEPTH = 4;

    // Branch codes as reported on branch_taken
    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

endpackage
`default_nettype wire

// ----- rtl/core/rmq_mat_if.sv -----
// Matrix channel: valid/ready handshake with nine signed matrix elements.
`default_nettype none
interface rmq_mat_if #(parameter int DW = rmq_pkg::DATA_WIDTH_DEF);
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rmq_quat_if.sv -----
// Quaternion channel: valid/ready handshake with quaternion and flags.
`default_nettype none
interface rmq_quat_if #(parameter int DW = rmq_pkg::DATA_WIDTH_DEF);
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] quat_w, quat_x, quat_y, quat_z;
    logic [1:0]           branch_taken;
    logic                 degenerate;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, branch_taken, degenerate,
                    input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, branch_taken, degenerate,
                     output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rmq_front.sv -----
// Front end: accepts a matrix word, picks the branch and forms root argument and sums.
`default_nettype none
module rmq_front #(
    parameter int DW = rmq_pkg::DATA_WIDTH_DEF,
    parameter int FB = rmq_pkg::FRAC_BITS_DEF,
    parameter int EW = (DW + 3) + 3 * (DW + 1) + 3
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    rmq_mat_if.sink            mat,
    output logic               push,
    output logic [EW-1:0]      push_data,
    input  wire logic          full
);
    import rmq_pkg::*;

    localparam int AW  = DW + 3;
    localparam int DEW = DW + 1;
    localparam logic signed [AW-1:0] ONE = AW'(1) << FB;

    logic                  valid_reg;
    logic [EW-1:0]         data_reg;
    logic                  take;

    logic signed [AW-1:0]  trace, a_ii, a_jj, a_kk, arg;
    logic [1:0]            br;
    logic                  dg;
    logic signed [DEW-1:0] da, db, dc;

    // Classify: trace test, largest diagonal (lower index wins ties)
    always_comb
    begin
        trace = AW'(mat.m00) + AW'(mat.m11) + AW'(mat.m22);
        if (trace > 0)
        begin
            br = BR_TRACE;
        end
        else if (mat.m22 > ((mat.m11 > mat.m00) ? mat.m11 : mat.m00))
        begin
            br = BR_Z;
        end
        else if (mat.m11 > mat.m00)
        begin
            br = BR_Y;
        end
        else
        begin
            br = BR_X;
        end

        a_ii = AW'(mat.m00);
        a_jj = AW'(mat.m11);
        a_kk = AW'(mat.m22);
        unique case (br)
            BR_TRACE:
            begin
                da = DEW'(mat.m21) - DEW'(mat.m12);
                db = DEW'(mat.m02) - DEW'(mat.m20);
                dc = DEW'(mat.m10) - DEW'(mat.m01);
            end
            BR_X:
            begin
                da = DEW'(mat.m21) - DEW'(mat.m12);
                db = DEW'(mat.m10) + DEW'(mat.m01);
                dc = DEW'(mat.m20) + DEW'(mat.m02);
            end
            BR_Y:
            begin
                a_ii = AW'(mat.m11);
                a_jj = AW'(mat.m22);
                a_kk = AW'(mat.m00);
                da = DEW'(mat.m02) - DEW'(mat.m20);
                db = DEW'(mat.m21) + DEW'(mat.m12);
                dc = DEW'(mat.m01) + DEW'(mat.m10);
            end
            default:
            begin
                a_ii = AW'(mat.m22);
                a_jj = AW'(mat.m00);
                a_kk = AW'(mat.m11);
                da = DEW'(mat.m10) - DEW'(mat.m01);
                db = DEW'(mat.m02) + DEW'(mat.m20);
                dc = DEW'(mat.m12) + DEW'(mat.m21);
            end
        endcase

        // Root argument with clamp to one LSB
        dg = 1'b0;
        if (br == BR_TRACE)
        begin
            arg = trace + ONE;
        end
        else
        begin
            arg = a_ii - a_jj - a_kk + ONE;
            if (arg <= 0)
            begin
                arg = AW'(1);
                dg  = 1'b1;
            end
        end
    end

    // One-word holding stage ahead of the queue
    assign push      = valid_reg && !full;
    assign mat.ready = !valid_reg || !full;
    assign take      = mat.valid && mat.ready;
    assign push_data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (mat.ready)
        begin
            valid_reg <= mat.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= {arg, da, db, dc, br, dg};
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/rmq_queue.sv -----
// Short queue between the classify stage and the arithmetic pipeline.
`default_nettype none
module rmq_queue #(
    parameter int EW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [EW-1:0] push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output logic [EW-1:0]      head
);
    import rmq_pkg::*;

    localparam int PTRW = $clog2(QUEUE_DEPTH);

    logic [EW-1:0]   mem_reg [QUEUE_DEPTH];
    logic [PTRW-1:0] wr_reg, rd_reg;
    logic [PTRW:0]   cnt_reg;

    assign full  = (cnt_reg == (PTRW+1)'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/rmq_back.sv -----
// Back end: pipelined square root, three pipelined dividers, saturation and output register.
`default_nettype none
module rmq_back #(
    parameter int DW = rmq_pkg::DATA_WIDTH_DEF,
    parameter int FB = rmq_pkg::FRAC_BITS_DEF,
    parameter int EW = (DW + 3) + 3 * (DW + 1) + 3
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          empty,
    input  wire logic [EW-1:0] head,
    output logic               pop,
    rmq_quat_if.source         quat
);
    import rmq_pkg::*;

    localparam int AW  = DW + 3;
    localparam int DEW = DW + 1;
    localparam int RW  = AW + FB;
    localparam int SB  = (RW + 1) / 2;
    localparam int PW  = 2 * SB;
    localparam int NW  = DW + FB + 2;

    logic adv;

    // Pipeline advances whenever the output register can take a word
    assign adv = !quat.valid || quat.ready;
    assign pop = adv && !empty;

    // Square root stages
    logic [PW-1:0]         sq_rad  [SB+1];
    logic [SB:0]           sq_rem  [SB+1];
    logic [SB-1:0]         sq_root [SB+1];
    logic signed [DEW-1:0] sq_d    [SB+1][3];
    logic [1:0]            sq_br   [SB+1];
    logic                  sq_dg   [SB+1];
    logic                  sq_v    [SB+1];

    logic [AW-1:0]         h_arg;
    logic signed [DEW-1:0] h_da, h_db, h_dc;
    logic [1:0]            h_br;
    logic                  h_dg;

    assign {h_arg, h_da, h_db, h_dc, h_br, h_dg} = head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_v[0] <= !empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rad[0]  <= PW'({h_arg, {FB{1'b0}}});
            sq_rem[0]  <= '0;
            sq_root[0] <= '0;
            sq_d[0][0] <= h_da;
            sq_d[0][1] <= h_db;
            sq_d[0][2] <= h_dc;
            sq_br[0]   <= h_br;
            sq_dg[0]   <= h_dg;
        end
    end

    for (genvar g = 0; g < SB; g++)
    begin : g_sq
        logic [SB+2:0] rem_sh, trial;
        logic          ge;

        // One result bit per stage
        always_comb
        begin
            rem_sh = {sq_rem[g], sq_rad[g][PW-1 -: 2]};
            trial  = {1'b0, sq_root[g], 2'b01};
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v[g+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_v[g+1] <= sq_v[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rad[g+1]  <= {sq_rad[g][PW-3:0], 2'b00};
                sq_rem[g+1]  <= (SB+1)'(ge ? (rem_sh - trial) : rem_sh);
                sq_root[g+1] <= {sq_root[g][SB-2:0], ge};
                sq_d[g+1]    <= sq_d[g];
                sq_br[g+1]   <= sq_br[g];
                sq_dg[g+1]   <= sq_dg[g];
            end
        end
    end

    // Divider stages: d * 2^FB / (2r), rounded, three lanes
    logic [NW-1:0]   dv_num [NW+1][3];
    logic [NW-1:0]   dv_q   [NW+1][3];
    logic [SB:0]     dv_rem [NW+1][3];
    logic [2:0]      dv_neg [NW+1];
    logic [SB-1:0]   dv_root[NW+1];
    logic [1:0]      dv_br  [NW+1];
    logic            dv_dg  [NW+1];
    logic            dv_v   [NW+1];

    logic [SB:0]     r_ext;
    logic [DEW-1:0]  mag [3];

    always_comb
    begin
        r_ext = {1'b0, sq_root[SB]};
        for (int c = 0; c < 3; c++)
        begin
            mag[c] = sq_d[SB][c][DEW-1] ? DEW'(-sq_d[SB][c]) : DEW'(sq_d[SB][c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_v[0] <= sq_v[SB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                dv_num[0][c] <= NW'({mag[c], {FB{1'b0}}}) + NW'(r_ext);
                dv_q[0][c]   <= '0;
                dv_rem[0][c] <= '0;
                dv_neg[0][c] <= sq_d[SB][c][DEW-1];
            end
            dv_root[0] <= sq_root[SB];
            dv_br[0]   <= sq_br[SB];
            dv_dg[0]   <= sq_dg[SB];
        end
    end

    for (genvar s = 0; s < NW; s++)
    begin : g_dv
        logic [SB+1:0] den;

        assign den = {1'b0, dv_root[s], 1'b0};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v[s+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_v[s+1] <= dv_v[s];
            end
        end

        for (genvar c = 0; c < 3; c++)
        begin : g_lane
            logic [SB+1:0] rem_sh;
            logic          ge;

            always_comb
            begin
                rem_sh = {dv_rem[s][c], dv_num[s][c][NW-1]};
                ge     = (rem_sh >= den);
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_num[s+1][c] <= {dv_num[s][c][NW-2:0], 1'b0};
                    dv_rem[s+1][c] <= (SB+1)'(ge ? (rem_sh - den) : rem_sh);
                    dv_q[s+1][c]   <= {dv_q[s][c][NW-2:0], ge};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_neg[s+1]  <= dv_neg[s];
                dv_root[s+1] <= dv_root[s];
                dv_br[s+1]   <= dv_br[s];
                dv_dg[s+1]   <= dv_dg[s];
            end
        end
    end

    // Saturate a sign and magnitude to the signed output range
    function automatic logic [DW-1:0] sat(input logic neg, input logic [NW-1:0] m);
        logic [NW-1:0] lim;
        logic [DW-1:0] res;
        lim = NW'(1) << (DW - 1);
        if (neg)
        begin
            res = (m >= lim) ? DW'(lim) : DW'(~m + 1'b1);
        end
        else
        begin
            res = (m > lim - 1'b1) ? DW'(lim - 1'b1) : DW'(m);
        end
        return res;
    endfunction

    logic [SB:0]   half_root;
    logic [DW-1:0] q_rt, q_a, q_b, q_c;
    logic [DW-1:0] w_n, x_n, y_n, z_n;

    // Map root component and quotients onto w, x, y, z
    always_comb
    begin
        half_root = ({1'b0, dv_root[NW]} + 1'b1) >> 1;
        q_rt = sat(1'b0, NW'(half_root));
        q_a  = sat(dv_neg[NW][0], dv_q[NW][0]);
        q_b  = sat(dv_neg[NW][1], dv_q[NW][1]);
        q_c  = sat(dv_neg[NW][2], dv_q[NW][2]);
        unique case (dv_br[NW])
            BR_TRACE:
            begin
                w_n = q_rt; x_n = q_a;  y_n = q_b;  z_n = q_c;
            end
            BR_X:
            begin
                w_n = q_a;  x_n = q_rt; y_n = q_b;  z_n = q_c;
            end
            BR_Y:
            begin
                w_n = q_a;  x_n = q_c;  y_n = q_rt; z_n = q_b;
            end
            default:
            begin
                w_n = q_a;  x_n = q_b;  y_n = q_c;  z_n = q_rt;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat.valid <= 1'b0;
        end
        else if (adv)
        begin
            quat.valid <= dv_v[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quat.quat_w       <= w_n;
            quat.quat_x       <= x_n;
            quat.quat_y       <= y_n;
            quat.quat_z       <= z_n;
            quat.branch_taken <= dv_br[NW];
            quat.degenerate   <= dv_dg[NW];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/rotation_matrix_to_quaternion.sv -----
// Top level: rotation matrix to unit quaternion, trace method, fixed point.
//
//   channel | dir | payload                                       | handshake
//   mat     | in  | m00..m22, signed Q2.14                        | valid/ready
//   quat    | out | quat_w..quat_z, branch_taken, degenerate      | valid/ready
//
// One word per cycle sustained while the output side is ready. The arithmetic pipeline has
// SB = ceil((DATA_WIDTH+FRAC_BITS+3)/2) square-root stages and NW = DATA_WIDTH + FRAC_BITS + 2
// divider stages. The output register stalls the whole arithmetic pipeline; the four-word
// queue keeps the front end taking words meanwhile. Reset clears valid flags, queue pointers
// and the queue fill count only.
`default_nettype none
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rmq_mat_if.sink    mat,
    rmq_quat_if.source quat
);
    import rmq_pkg::*;

    localparam int EW = (DATA_WIDTH + 3) + 3 * (DATA_WIDTH + 1) + 3;

    logic          push, full, pop, empty;
    logic [EW-1:0] push_data, head;

    rmq_front #(.DW(DATA_WIDTH), .FB(FRAC_BITS), .EW(EW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat       (mat),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    rmq_queue #(.EW(EW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    rmq_back #(.DW(DATA_WIDTH), .FB(FRAC_BITS), .EW(EW)) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (empty),
        .head  (head),
        .pop   (pop),
        .quat  (quat)
    );

endmodule
`default_nettype wire

// ----- rtl/core/rmq_checker.sv -----
// Port-level checks for the rotation matrix to quaternion block, bound to the top level.
`default_nettype none
module rmq_checker #(
    parameter int DW = rmq_pkg::DATA_WIDTH_DEF
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic signed [DW-1:0] quat_w,
    input wire logic signed [DW-1:0] quat_x,
    input wire logic [1:0]           branch_taken,
    input wire logic                 degenerate
);
    import rmq_pkg::*;

    logic [7:0] cnt_reg;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Words inside the block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != 8'd0)
        else $error("output word with nothing accepted");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(quat_w) && $stable(branch_taken))
        else $error("stalled output word changed");

    a_trace_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && branch_taken == BR_TRACE |-> !degenerate && !quat_w[DW-1])
        else $error("trace branch with clamp or negative w");

    a_x_root: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && branch_taken == BR_X |-> !quat_x[DW-1])
        else $error("x branch with negative x");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(.DW(DATA_WIDTH)) u_rmq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (mat.valid),
    .in_ready     (mat.ready),
    .out_valid    (quat.valid),
    .out_ready    (quat.ready),
    .quat_w       (quat.quat_w),
    .quat_x       (quat.quat_x),
    .branch_taken (quat.branch_taken),
    .degenerate   (quat.degenerate)
);
`default_nettype wire

// ----- tb/rotation_matrix_to_quaternion_tb.sv -----
// Testbench for the rotation matrix to quaternion block: directed table, then random matrices.
`default_nettype none
module rotation_matrix_to_quaternion_tb;
    import rmq_pkg::*;

    localparam int DW = DATA_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam longint ONE = longint'(1) << FB;
    localparam int unsigned AXIS_NEXT [3] = '{1, 2, 0};
    localparam int N_RANDOM = 1880;

    typedef logic [8:0][DW-1:0] mat_t;
    typedef struct packed {
        logic [DW-1:0] w, x, y, z;
        logic [1:0]    br;
        logic          dg;
    } quat_t;
    typedef struct packed {
        mat_t  m;
        bit    typed;
        quat_t q;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rmq_mat_if  #(.DW(DW)) mat_ch ();
    rmq_quat_if #(.DW(DW)) quat_ch ();

    rotation_matrix_to_quaternion u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .mat   (mat_ch.sink),
        .quat  (quat_ch.source)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    quat_t pending_quats [$];
    int    errors = 0;
    int    send_idle_pct = 0;
    int    stall_pct = 0;

    // Integer square root, bit by bit
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = longint'(1) << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [DW-1:0] clip(bit neg, longint mag);
        longint lim;
        lim = longint'(1) << (DW - 1);
        if (neg)
            return (mag >= lim) ? DW'(lim) : DW'(-mag);
        return (mag > lim - 1) ? DW'(lim - 1) : DW'(mag);
    endfunction

    // d * 2^FB / (2r), rounded to nearest with ties away from zero
    function automatic logic [DW-1:0] ratio(longint d, longint r);
        bit     neg;
        longint mag;
        neg = d < 0;
        mag = neg ? -d : d;
        return clip(neg, ((mag << FB) + r) / (2 * r));
    endfunction

    function automatic quat_t predict_quat(mat_t a);
        longint      e [9];
        longint      tr, arg, r;
        logic [DW-1:0] q [4];
        int unsigned i, j, k;
        quat_t       res;
        for (int n = 0; n < 9; n++)
            e[n] = longint'($signed(a[n]));
        res.dg = 1'b0;
        tr = e[0] + e[4] + e[8];
        if (tr > 0)
        begin
            r = longint'(root_floor(longint'(tr + ONE) << FB));
            q[0] = clip(1'b0, (r + 1) >> 1);
            q[1] = ratio(e[7] - e[5], r);
            q[2] = ratio(e[2] - e[6], r);
            q[3] = ratio(e[3] - e[1], r);
            res.br = BR_TRACE;
        end
        else
        begin
            // largest diagonal element, lower index on ties
            i = 0;
            if (e[4] > e[0])
                i = 1;
            if (e[8] > e[i*4])
                i = 2;
            j = AXIS_NEXT[i];
            k = AXIS_NEXT[j];
            arg = e[i*4] - e[j*4] - e[k*4] + ONE;
            if (arg <= 0)
            begin
                arg = 1;
                res.dg = 1'b1;
            end
            r = longint'(root_floor(arg << FB));
            q[1+i] = clip(1'b0, (r + 1) >> 1);
            q[0]   = ratio(e[k*3+j] - e[j*3+k], r);
            q[1+j] = ratio(e[j*3+i] + e[i*3+j], r);
            q[1+k] = ratio(e[k*3+i] + e[i*3+k], r);
            case (i)
                0: res.br = BR_X;
                1: res.br = BR_Y;
                default: res.br = BR_Z;
            endcase
        end
        res.w = q[0];
        res.x = q[1];
        res.y = q[2];
        res.z = q[3];
        return res;
    endfunction

    function automatic mat_t mk(int a00, int a01, int a02, int a10, int a11, int a12,
                                int a20, int a21, int a22);
        return {DW'(a22), DW'(a21), DW'(a20), DW'(a12), DW'(a11), DW'(a10),
                DW'(a02), DW'(a01), DW'(a00)};
    endfunction

    function automatic quat_t mkq(int w, int x, int y, int z, logic [1:0] br);
        quat_t q;
        q.w = DW'(w);
        q.x = DW'(x);
        q.y = DW'(y);
        q.z = DW'(z);
        q.br = br;
        q.dg = 1'b0;
        return q;
    endfunction

    function automatic logic [DW-1:0] rand_elem(int kind);
        int pick;
        case (kind)
            0: return DW'($urandom);
            1: return DW'(int'($urandom_range(0, 32768)) - 16384);
            default:
            begin
                pick = $urandom_range(0, 4);
                case (pick)
                    0: return DW'(-32768);
                    1: return DW'(32767);
                    2: return '0;
                    3: return DW'(16384);
                    default: return DW'(-16384);
                endcase
            end
        endcase
    endfunction

    // Random matrix: mostly rotation-sized entries, some full range and corner values
    function automatic mat_t rand_mat();
        mat_t a;
        int   sel, kind;
        sel = $urandom_range(0, 9);
        kind = (sel < 3) ? 0 : (sel < 9) ? 1 : 2;
        for (int n = 0; n < 9; n++)
            a[n] = rand_elem(kind);
        // force diagonal ties now and then
        if ($urandom_range(0, 7) == 0)
            a[4] = a[0];
        if ($urandom_range(0, 7) == 0)
            a[8] = a[4];
        return a;
    endfunction

    task automatic report(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Send one word, after an optional random idle gap, and wait for the handshake
    task automatic send_mat(mat_t a, quat_t want);
        bit hs;
        int idle;
        idle = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
        if (idle > 0)
        begin
            mat_ch.valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        mat_ch.valid <= 1'b1;
        {mat_ch.m22, mat_ch.m21, mat_ch.m20, mat_ch.m12, mat_ch.m11, mat_ch.m10,
         mat_ch.m02, mat_ch.m01, mat_ch.m00} <= a;
        do
        begin
            @(negedge clk);
            hs = mat_ch.ready;
            @(posedge clk);
        end
        while (!hs);
        pending_quats.push_back(want);
    endtask

    // Receiver: random stalls, compare each accepted word at the falling edge
    always @(posedge clk)
        quat_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(negedge clk)
    begin
        quat_t got, want;
        if (rst_n && quat_ch.valid && quat_ch.ready)
        begin
            got = {quat_ch.quat_w, quat_ch.quat_x, quat_ch.quat_y, quat_ch.quat_z,
                   quat_ch.branch_taken, quat_ch.degenerate};
            if (pending_quats.size() == 0)
                report("unexpected word", 0, 0);
            else
            begin
                want = pending_quats.pop_front();
                if (got.w !== want.w)
                    report("quat_w", $signed(got.w), $signed(want.w));
                if (got.x !== want.x)
                    report("quat_x", $signed(got.x), $signed(want.x));
                if (got.y !== want.y)
                    report("quat_y", $signed(got.y), $signed(want.y));
                if (got.z !== want.z)
                    report("quat_z", $signed(got.z), $signed(want.z));
                if (got.br !== want.br)
                    report("branch_taken", got.br, want.br);
                if (got.dg !== want.dg)
                    report("degenerate", got.dg, want.dg);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        row_t dir_rows [$];
        row_t row;
        int   idle_set [4];
        int   stall_set [4];
        int   cnt;
        mat_ch.valid = 1'b0;
        {mat_ch.m22, mat_ch.m21, mat_ch.m20, mat_ch.m12, mat_ch.m11, mat_ch.m10,
         mat_ch.m02, mat_ch.m01, mat_ch.m00} = '0;
        quat_ch.ready = 1'b0;
        idle_set  = '{0, 87, 0, 14};
        stall_set = '{0, 0, 87, 14};

        // Directed table: typed results where they are obvious
        row = '0; row.typed = 1;
        row.m = mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
        row.q = mkq(16384, 0, 0, 0, BR_TRACE);                      dir_rows.push_back(row);
        row.m = '0;  // zero trace takes the diagonal branch
        row.q = mkq(0, 8192, 0, 0, BR_X);                           dir_rows.push_back(row);
        row.m = mk(16384, 0, 0, 0, -16384, 0, 0, 0, -16384);
        row.q = mkq(0, 16384, 0, 0, BR_X);                          dir_rows.push_back(row);
        row.m = mk(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384);
        row.q = mkq(0, 0, 16384, 0, BR_Y);                          dir_rows.push_back(row);
        row.m = mk(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384);
        row.q = mkq(0, 0, 0, 16384, BR_Z);                          dir_rows.push_back(row);
        // saturation of w both ways
        row.m = mk(0, 0, 0, 0, 0, -32768, 0, 32767, 0);
        row.q = mkq(32767, 8192, 0, 0, BR_X);                       dir_rows.push_back(row);
        row.m = mk(0, 0, 0, 0, 0, 32767, 0, -32768, 0);
        row.q = mkq(-32768, 8192, 0, 0, BR_X);                      dir_rows.push_back(row);
        // predictor-checked rows: extremes, ties, off-diagonal corners
        row.typed = 0;
        row.m = mk(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768);       dir_rows.push_back(row);
        row.m = mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        dir_rows.push_back(row);
        row.m = mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        dir_rows.push_back(row);
        row.m = mk(-16384, 32767, -32768, -32768, -16384, 32767, 32767, -32768, -16384);
        dir_rows.push_back(row);
        row.m = mk(0, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0);
        dir_rows.push_back(row);
        row.m = mk(1, 0, 0, 0, 0, 0, 0, 0, -1);                     dir_rows.push_back(row);
        row.m = mk(-5, 0, 0, 0, -5, 0, 0, 0, 10);                   dir_rows.push_back(row);
        row.m = mk(0, 11585, -11585, -11585, 0, 11585, 11585, -11585, 0);
        dir_rows.push_back(row);
        row.m = mk(32767, 0, 0, 0, 32767, 0, 0, 0, -32768);         dir_rows.push_back(row);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[n])
            send_mat(dir_rows[n].m,
                     dir_rows[n].typed ? dir_rows[n].q : predict_quat(dir_rows[n].m));

        // Random part in four phases of sender idling and receiver stalls
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = idle_set[ph];
            stall_pct = stall_set[ph];
            cnt = N_RANDOM / 4;
            for (int n = 0; n < cnt; n++)
            begin
                mat_t a;
                a = rand_mat();
                send_mat(a, predict_quat(a));
            end
            // after the second phase the sender holds off until the pipeline has drained
            if (ph == 1)
            begin
                mat_ch.valid <= 1'b0;
                while (pending_quats.size() != 0)
                    @(posedge clk);
            end
        end
        mat_ch.valid <= 1'b0;
        stall_pct = 0;

        while (pending_quats.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
